FILE: rtl/core/ucdp_pkg.sv
package ucdp_pkg;

  localparam int POS_W = 10;
  localparam logic [POS_W-1:0] POS_LIMIT = '1;

  localparam logic [7:0] KIND_INTERFACE = 8'd4;
  localparam logic [7:0] KIND_ENDPOINT = 8'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_TOTAL = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_NO_IFACE = 2'd3;

  localparam logic [10:0] PACKET_MASK = 11'h7FF;
  localparam logic [10:0] PACKET_DEFAULT = 11'd8;
  localparam logic [7:0] INTERVAL_DEFAULT = 8'd8;
  localparam logic [3:0] SPEED_RESET = 4'd3;
  localparam logic [3:0] SPEED_LOW = 4'd1;
  localparam logic [3:0] SPEED_FULL = 4'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  cfg_value;
    logic [7:0]  iface_num;
    logic [7:0]  iface_class;
    logic [7:0]  iface_sub;
    logic [7:0]  iface_proto;
    logic [7:0]  ep_addr;
    logic [10:0] ep_packet;
    logic [7:0]  ep_interval;
  } ucdp_summary_t;

  // Millisecond links get the smallest exponent e in 3..10 with 2^e >= 8 * raw, or 10 if none fits.
  function automatic logic [7:0] ucdp_convert_interval(input logic [3:0] speed,
                                                       input logic [7:0] raw);
    logic [7:0] e;
    begin
      if (speed == SPEED_LOW || speed == SPEED_FULL) begin
        priority if (raw <= 8'd1) e = 8'd3;
        else if (raw <= 8'd2) e = 8'd4;
        else if (raw <= 8'd4) e = 8'd5;
        else if (raw <= 8'd8) e = 8'd6;
        else if (raw <= 8'd16) e = 8'd7;
        else if (raw <= 8'd32) e = 8'd8;
        else if (raw <= 8'd64) e = 8'd9;
        else e = 8'd10;
      end else begin
        e = (raw != 8'd0) ? raw - 8'd1 : 8'd0;
      end
      return e;
    end
  endfunction

endpackage

FILE: rtl/core/ucdp_walker.sv
module ucdp_walker #(
  parameter int MAX_TOTAL = 512
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output ucdp_pkg::ucdp_summary_t summary
);
  import ucdp_pkg::*;

  localparam logic [15:0] TOTAL_MAX = 16'(MAX_TOTAL);
  localparam logic [15:0] TOTAL_MIN = 16'd9;

  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      total, total_next;
  logic [POS_W-1:0] start, start_next;
  logic [7:0]       len, len_next;
  logic [7:0]       kind, kind_next;
  logic             iface_seen, iface_seen_next;
  logic             stopped, stopped_next;
  logic [7:0]       pending [4];
  logic [7:0]       pending_next [4];
  logic [7:0]       cfg_value, cfg_value_next;
  logic [7:0]       iface_num, iface_num_next;
  logic [7:0]       iface_class, iface_class_next;
  logic [7:0]       iface_sub, iface_sub_next;
  logic [7:0]       iface_proto, iface_proto_next;
  logic [7:0]       ep_addr, ep_addr_next;
  logic [10:0]      ep_packet, ep_packet_next;
  logic [7:0]       ep_interval, ep_interval_next;
  logic             ep_ok, ep_ok_next;
  logic [7:0]       ep_ivl, ep_ivl_next;

  logic             total_ok;
  logic             active;
  logic [POS_W-1:0] off;
  logic             len_bad;
  logic             total_ok_next;

  assign total_ok = (total >= TOTAL_MIN) && (total <= TOTAL_MAX);
  assign active = (pos < POS_W'(4)) || (total_ok && (16'(pos) < total));
  assign off = pos - start;

  always_comb begin
    pos_next = pos;
    total_next = total;
    start_next = start;
    len_next = len;
    kind_next = kind;
    iface_seen_next = iface_seen;
    stopped_next = stopped;
    pending_next = pending;
    cfg_value_next = cfg_value;
    iface_num_next = iface_num;
    iface_class_next = iface_class;
    iface_sub_next = iface_sub;
    iface_proto_next = iface_proto;
    ep_addr_next = ep_addr;
    ep_packet_next = ep_packet;
    ep_interval_next = ep_interval;
    ep_ok_next = ep_ok;
    ep_ivl_next = ep_ivl;
    len_bad = 1'b0;

    if (fire) begin
      if (active) begin
        if (pos == POS_W'(2)) begin
          total_next = {8'd0, data_byte};
        end else if (pos == POS_W'(3)) begin
          total_next = {data_byte, total[7:0]};
        end else if (pos == POS_W'(5)) begin
          cfg_value_next = data_byte;
        end

        if (!stopped) begin
          if (off == '0) begin
            len_next = data_byte;
            kind_next = 8'd0;
            ep_ok_next = 1'b0;
            if (data_byte < 8'd2) begin
              stopped_next = 1'b1;
              len_bad = 1'b1;
            end
          end else if (off == POS_W'(1)) begin
            kind_next = data_byte;
          end else if (kind == KIND_INTERFACE) begin
            if (off == POS_W'(2)) pending_next[0] = data_byte;
            if (off == POS_W'(5)) pending_next[1] = data_byte;
            if (off == POS_W'(6)) pending_next[2] = data_byte;
            if (off == POS_W'(7)) pending_next[3] = data_byte;
          end else if (kind == KIND_ENDPOINT) begin
            if (off == POS_W'(2)) pending_next[0] = data_byte;
            if (off == POS_W'(3)) begin
              pending_next[1] = data_byte;
              ep_ok_next = (data_byte[1:0] == 2'b11) && pending[0][7];
            end
            if (off == POS_W'(4)) pending_next[2] = data_byte;
            if (off == POS_W'(5)) pending_next[3] = data_byte;
            if (off == POS_W'(6)) ep_ivl_next = data_byte;
          end

          if (!len_bad && ((11'(off) + 11'd1) == 11'(len_next))) begin
            if (kind_next == KIND_INTERFACE && len_next >= 8'd9) begin
              if (iface_seen && ep_addr != 8'd0) begin
                stopped_next = 1'b1;
              end else begin
                iface_num_next = pending_next[0];
                iface_class_next = pending_next[1];
                iface_sub_next = pending_next[2];
                iface_proto_next = pending_next[3];
                iface_seen_next = 1'b1;
                ep_addr_next = 8'd0;
              end
            end else if (kind_next == KIND_ENDPOINT && len_next >= 8'd7 &&
                         iface_seen && ep_ok_next) begin
              ep_addr_next = pending_next[0];
              ep_packet_next = {pending_next[3][2:0], pending_next[2]} & PACKET_MASK;
              ep_interval_next = ep_ivl_next;
            end
            if (!(kind_next == KIND_INTERFACE && len_next >= 8'd9 &&
                  iface_seen && ep_addr != 8'd0)) begin
              start_next = pos + POS_W'(1);
            end else begin
              start_next = pos + POS_W'(1);
            end
          end
        end
      end
      pos_next = (pos == POS_LIMIT) ? pos : pos + POS_W'(1);
    end

    total_ok_next = (total_next >= TOTAL_MIN) && (total_next <= TOTAL_MAX);
    priority if (pos_next < POS_W'(4)) summary.status = ST_TRUNCATED;
    else if (!total_ok_next) summary.status = ST_BAD_TOTAL;
    else if (16'(pos_next) < total_next) summary.status = ST_TRUNCATED;
    else if (!iface_seen_next) summary.status = ST_NO_IFACE;
    else summary.status = ST_OK;
    summary.cfg_value = cfg_value_next;
    summary.iface_num = iface_num_next;
    summary.iface_class = iface_class_next;
    summary.iface_sub = iface_sub_next;
    summary.iface_proto = iface_proto_next;
    summary.ep_addr = ep_addr_next;
    summary.ep_packet = ep_packet_next;
    summary.ep_interval = ep_interval_next;

    if (fire && last_byte) begin
      pos_next = '0;
      total_next = '0;
      start_next = '0;
      len_next = '0;
      kind_next = '0;
      iface_seen_next = 1'b0;
      stopped_next = 1'b0;
      pending_next = '{default: 8'd0};
      cfg_value_next = '0;
      iface_num_next = '0;
      iface_class_next = '0;
      iface_sub_next = '0;
      iface_proto_next = '0;
      ep_addr_next = '0;
      ep_packet_next = PACKET_DEFAULT;
      ep_interval_next = INTERVAL_DEFAULT;
      ep_ok_next = 1'b0;
      ep_ivl_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      total <= '0;
      start <= '0;
      len <= '0;
      kind <= '0;
      iface_seen <= 1'b0;
      stopped <= 1'b0;
      pending <= '{default: 8'd0};
      cfg_value <= '0;
      iface_num <= '0;
      iface_class <= '0;
      iface_sub <= '0;
      iface_proto <= '0;
      ep_addr <= '0;
      ep_packet <= PACKET_DEFAULT;
      ep_interval <= INTERVAL_DEFAULT;
      ep_ok <= 1'b0;
      ep_ivl <= '0;
    end else begin
      pos <= pos_next;
      total <= total_next;
      start <= start_next;
      len <= len_next;
      kind <= kind_next;
      iface_seen <= iface_seen_next;
      stopped <= stopped_next;
      pending <= pending_next;
      cfg_value <= cfg_value_next;
      iface_num <= iface_num_next;
      iface_class <= iface_class_next;
      iface_sub <= iface_sub_next;
      iface_proto <= iface_proto_next;
      ep_addr <= ep_addr_next;
      ep_packet <= ep_packet_next;
      ep_interval <= ep_interval_next;
      ep_ok <= ep_ok_next;
      ep_ivl <= ep_ivl_next;
    end
  end

`ifndef SYNTHESIS
  a_start_behind_pos: assert property (@(posedge clk) disable iff (rst)
    start <= pos)
    else $error("Descriptor start is ahead of the byte position.");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && last_byte |=> pos == '0 && !stopped && !iface_seen)
    else $error("Walk state was not cleared after the last byte.");

  a_recorded_addr_is_in: assert property (@(posedge clk) disable iff (rst)
    ep_addr != 8'd0 |-> ep_addr[7] && iface_seen)
    else $error("Recorded endpoint is not an IN endpoint of an interface.");
`endif

endmodule

FILE: rtl/core/ucdp_result.sv
module ucdp_result (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   capture,
  input  ucdp_pkg::ucdp_summary_t summary,
  input  logic [3:0]             link_speed,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [1:0]             status,
  output logic [7:0]             config_value,
  output logic [7:0]             iface_number,
  output logic [7:0]             iface_class,
  output logic [7:0]             iface_subclass,
  output logic [7:0]             iface_protocol,
  output logic                   endpoint_found,
  output logic [7:0]             ep_address,
  output logic [10:0]            ep_max_packet,
  output logic [7:0]             ep_poll_interval
);
  import ucdp_pkg::*;

  logic good;
  logic ep;

  assign good = (summary.status == ST_OK);
  assign ep = good && (summary.ep_addr != 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      status <= summary.status;
      config_value <= summary.cfg_value;
      iface_number <= good ? summary.iface_num : 8'd0;
      iface_class <= good ? summary.iface_class : 8'd0;
      iface_subclass <= good ? summary.iface_sub : 8'd0;
      iface_protocol <= good ? summary.iface_proto : 8'd0;
      endpoint_found <= ep;
      ep_address <= ep ? summary.ep_addr : 8'd0;
      ep_max_packet <= ep ? (summary.ep_packet & PACKET_MASK) : PACKET_DEFAULT;
      ep_poll_interval <= ep ? ucdp_convert_interval(link_speed, summary.ep_interval)
                             : 8'd0;
    end
  end

`ifndef SYNTHESIS
  a_fail_clears_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      !endpoint_found && ep_max_packet == PACKET_DEFAULT && iface_number == 8'd0)
    else $error("A failed result carries interface or endpoint data.");

  a_no_ep_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !endpoint_found |-> ep_address == 8'd0 && ep_poll_interval == 8'd0)
    else $error("Endpoint fields are set without an endpoint.");

  a_found_is_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && endpoint_found |-> ep_address[7])
    else $error("Reported endpoint is not an IN endpoint.");
`endif

endmodule

FILE: rtl/core/usb_config_descriptor_parser_top.sv
// Walks a USB configuration descriptor set that arrives one byte per item and
// takes one byte in every clock cycle, save for the last_byte hold-off below.
// Bytes 2 and 3 give the total length; bytes past it are ignored. On the item
// with last_byte set, one result appears on the output channel in the next
// cycle, carrying the configuration value and the first interface with an
// interrupt IN endpoint (else the last interface), and the parser then starts
// over on a new stream. While an earlier result waits on out_ready, only an
// item with last_byte set is held off; other bytes keep flowing. The user must
// write the link speed register through the cfg channel only while no stream
// is in progress (the block does not enforce this); codes 1 and 2 turn the endpoint interval into an exponent.
module usb_config_descriptor_parser_top #(
  parameter int MAX_TOTAL = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  config_value,
  output logic [7:0]  iface_number,
  output logic [7:0]  iface_class,
  output logic [7:0]  iface_subclass,
  output logic [7:0]  iface_protocol,
  output logic        endpoint_found,
  output logic [7:0]  ep_address,
  output logic [10:0] ep_max_packet,
  output logic [7:0]  ep_poll_interval,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  import ucdp_pkg::*;

  logic          fire;
  logic [3:0]    link_speed;
  ucdp_summary_t summary;

  assign in_ready = !out_valid || out_ready || !last_byte;
  assign fire = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_speed <= SPEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      link_speed <= cfg_data;
    end
  end

  ucdp_walker #(
    .MAX_TOTAL(MAX_TOTAL)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .summary  (summary)
  );

  ucdp_result u_result (
    .clk             (clk),
    .rst             (rst),
    .capture         (fire && last_byte),
    .summary         (summary),
    .link_speed      (link_speed),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .status          (status),
    .config_value    (config_value),
    .iface_number    (iface_number),
    .iface_class     (iface_class),
    .iface_subclass  (iface_subclass),
    .iface_protocol  (iface_protocol),
    .endpoint_found  (endpoint_found),
    .ep_address      (ep_address),
    .ep_max_packet   (ep_max_packet),
    .ep_poll_interval(ep_poll_interval)
  );

endmodule

FILE: tb/ucdp_summary_checker.sv
module ucdp_summary_checker #(
  parameter int MAX_TOTAL = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [7:0]  config_value,
  input  logic [7:0]  iface_number,
  input  logic [7:0]  iface_class,
  input  logic [7:0]  iface_subclass,
  input  logic [7:0]  iface_protocol,
  input  logic        endpoint_found,
  input  logic [7:0]  ep_address,
  input  logic [10:0] ep_max_packet,
  input  logic [7:0]  ep_poll_interval,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output int unsigned fail_count,
  output int unsigned results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import ucdp_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  cfg_value;
    logic [7:0]  iface_num;
    logic [7:0]  iface_class;
    logic [7:0]  iface_sub;
    logic [7:0]  iface_proto;
    logic        ep_found;
    logic [7:0]  ep_addr;
    logic [10:0] ep_packet;
    logic [7:0]  ep_interval;
  } desc_summary_t;

  logic [3:0]      link_speed;
  logic [15:0]     byte_count;
  logic [15:0]     total_len;
  logic [15:0]     desc_start;
  logic [7:0]      desc_len;
  logic [7:0]      desc_kind;
  logic            iface_held;
  logic            walk_done;
  logic [3:0][7:0] field_buf;
  logic [3:0][7:0] iface_rec;
  logic [7:0]      cfg_byte;
  logic [7:0]      ep_addr_rec;
  logic [10:0]     ep_packet_rec;
  logic [7:0]      ep_interval_rec;
  logic            ep_match;
  logic [7:0]      ep_interval_raw;
  desc_summary_t   summaries_due[$];

  initial fail_count = 0;

  function automatic void restart_stream();
    byte_count = '0;
    total_len = '0;
    desc_start = '0;
    desc_len = '0;
    desc_kind = '0;
    iface_held = 1'b0;
    walk_done = 1'b0;
    field_buf = '0;
    iface_rec = '0;
    cfg_byte = '0;
    ep_addr_rec = '0;
    ep_packet_rec = PACKET_DEFAULT;
    ep_interval_rec = INTERVAL_DEFAULT;
    ep_match = 1'b0;
    ep_interval_raw = '0;
  endfunction

  function automatic logic total_ok();
    return total_len >= 16'd9 && total_len <= 16'(MAX_TOTAL);
  endfunction

  function automatic void close_descriptor();
    if (desc_kind == KIND_INTERFACE && desc_len >= 8'd9) begin
      if (iface_held && ep_addr_rec != 8'd0) begin
        walk_done = 1'b1;
      end else begin
        iface_rec = field_buf;
        iface_held = 1'b1;
        ep_addr_rec = 8'd0;
      end
    end else if (desc_kind == KIND_ENDPOINT && desc_len >= 8'd7 && iface_held && ep_match) begin
      ep_addr_rec = field_buf[0];
      ep_packet_rec = {field_buf[3][2:0], field_buf[2]} & PACKET_MASK;
      ep_interval_rec = ep_interval_raw;
    end
  endfunction

  function automatic void walk_descriptor(input logic [15:0] at, input logic [7:0] b);
    logic [15:0] off;
    off = at - desc_start;
    if (off == 16'd0) begin
      desc_len = b;
      desc_kind = 8'd0;
      ep_match = 1'b0;
      if (b < 8'd2) begin
        walk_done = 1'b1;
        return;
      end
    end else if (off == 16'd1) begin
      desc_kind = b;
    end else if (desc_kind == KIND_INTERFACE) begin
      if (off == 16'd2) field_buf[0] = b;
      else if (off >= 16'd5 && off <= 16'd7) field_buf[off - 16'd4] = b;
    end else if (desc_kind == KIND_ENDPOINT) begin
      if (off >= 16'd2 && off <= 16'd5) field_buf[off - 16'd2] = b;
      if (off == 16'd3) ep_match = (b[1:0] == 2'b11) && field_buf[0][7];
      if (off == 16'd6) ep_interval_raw = b;
    end
    if (off + 16'd1 == {8'd0, desc_len}) begin
      close_descriptor();
      desc_start = at + 16'd1;
    end
  endfunction

  function automatic logic [7:0] interval_code(input logic [7:0] raw);
    int unsigned e;
    if (link_speed == SPEED_LOW || link_speed == SPEED_FULL) begin
      e = 3;
      while ((32'd1 << e) < 32'(raw) * 32'd8 && e < 10) e++;
      return 8'(e);
    end
    return (raw != 8'd0) ? raw - 8'd1 : 8'd0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic fin);
    logic [15:0]   at;
    logic          live;
    logic          good;
    logic          ep;
    desc_summary_t s;
    at = byte_count;
    live = (at < 16'd4) || (total_ok() && at < total_len);
    if (live) begin
      if (at == 16'd2) total_len = {8'd0, b};
      else if (at == 16'd3) total_len = total_len | {b, 8'd0};
      else if (at == 16'd5) cfg_byte = b;
      if (!walk_done) walk_descriptor(at, b);
    end
    byte_count = (at < 16'(POS_LIMIT)) ? at + 16'd1 : 16'(POS_LIMIT);
    if (!fin) return;
    if (byte_count < 16'd4) s.status = ST_TRUNCATED;
    else if (!total_ok()) s.status = ST_BAD_TOTAL;
    else if (byte_count < total_len) s.status = ST_TRUNCATED;
    else if (!iface_held) s.status = ST_NO_IFACE;
    else s.status = ST_OK;
    good = (s.status == ST_OK);
    ep = good && ep_addr_rec != 8'd0;
    s.cfg_value = cfg_byte;
    s.iface_num = good ? iface_rec[0] : 8'd0;
    s.iface_class = good ? iface_rec[1] : 8'd0;
    s.iface_sub = good ? iface_rec[2] : 8'd0;
    s.iface_proto = good ? iface_rec[3] : 8'd0;
    s.ep_found = ep;
    s.ep_addr = ep ? ep_addr_rec : 8'd0;
    s.ep_packet = ep ? ep_packet_rec : PACKET_DEFAULT;
    s.ep_interval = ep ? interval_code(ep_interval_rec) : 8'd0;
    summaries_due.push_back(s);
    restart_stream();
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result();
    desc_summary_t want;
    if (summaries_due.size() == 0) begin
      report($sformatf("result item with status %0d arrived while none was due", status));
      return;
    end
    want = summaries_due.pop_front();
    compare_field("status", 16'(status), 16'(want.status));
    compare_field("config_value", 16'(config_value), 16'(want.cfg_value));
    compare_field("iface_number", 16'(iface_number), 16'(want.iface_num));
    compare_field("iface_class", 16'(iface_class), 16'(want.iface_class));
    compare_field("iface_subclass", 16'(iface_subclass), 16'(want.iface_sub));
    compare_field("iface_protocol", 16'(iface_protocol), 16'(want.iface_proto));
    compare_field("endpoint_found", 16'(endpoint_found), 16'(want.ep_found));
    compare_field("ep_address", 16'(ep_address), 16'(want.ep_addr));
    compare_field("ep_max_packet", 16'(ep_max_packet), 16'(want.ep_packet));
    compare_field("ep_poll_interval", 16'(ep_poll_interval), 16'(want.ep_interval));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      link_speed = SPEED_RESET;
      restart_stream();
      summaries_due.delete();
      results_owed <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) link_speed = cfg_data;
      if (in_valid && in_ready) absorb_byte(data_byte, last_byte);
      results_owed <= summaries_due.size();
    end
  end

endmodule

FILE: tb/tb_usb_config_descriptor_parser_top.sv
module tb_usb_config_descriptor_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TOTAL = 512;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_BUDGET = 700;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [7:0]  config_value;
  logic [7:0]  iface_number;
  logic [7:0]  iface_class;
  logic [7:0]  iface_subclass;
  logic [7:0]  iface_protocol;
  logic        endpoint_found;
  logic [7:0]  ep_address;
  logic [10:0] ep_max_packet;
  logic [7:0]  ep_poll_interval;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  int unsigned fail_count;
  int unsigned results_owed;

  logic [7:0]  frame_bytes[$];
  int          desc_offsets[$];
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  bit          in_steady;
  bit          out_steady;

  logic [15:0] bad_totals[4] = '{16'd8, 16'd513, 16'hFFFF, 16'd0};
  logic [3:0]  speed_codes[4] = '{4'd1, 4'd2, 4'd0, 4'd15};
  logic [7:0]  interval_set[6] = '{8'd0, 8'd1, 8'd2, 8'd9, 8'd65, 8'd255};
  logic [7:0]  short_lengths[2] = '{8'd0, 8'd1};

  usb_config_descriptor_parser_top #(.MAX_TOTAL(MAX_TOTAL)) i_dut (.*);

  ucdp_summary_checker #(.MAX_TOTAL(MAX_TOTAL)) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic play_stream();
    foreach (frame_bytes[i]) send_item(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
    desc_offsets.delete();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_speed(input logic [3:0] code);
    cfg_valid <= 1'b1;
    cfg_data <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic void put_header(input logic [7:0] cfg);
    desc_offsets.push_back(frame_bytes.size());
    frame_bytes.push_back(8'd9);
    frame_bytes.push_back(8'd2);
    frame_bytes.push_back(8'd0);
    frame_bytes.push_back(8'd0);
    frame_bytes.push_back(8'($urandom_range(0, 4)));
    frame_bytes.push_back(cfg);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_iface(input logic [7:0] num, input logic [7:0] cls,
                                    input logic [7:0] sub, input logic [7:0] proto);
    desc_offsets.push_back(frame_bytes.size());
    frame_bytes.push_back(8'd9);
    frame_bytes.push_back(8'd4);
    frame_bytes.push_back(num);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom_range(0, 3)));
    frame_bytes.push_back(cls);
    frame_bytes.push_back(sub);
    frame_bytes.push_back(proto);
    frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_endpoint(input logic [7:0] addr, input logic [7:0] attr,
                                       input logic [15:0] pkt, input logic [7:0] ivl);
    desc_offsets.push_back(frame_bytes.size());
    frame_bytes.push_back(8'd7);
    frame_bytes.push_back(8'd5);
    frame_bytes.push_back(addr);
    frame_bytes.push_back(attr);
    frame_bytes.push_back(pkt[7:0]);
    frame_bytes.push_back(pkt[15:8]);
    frame_bytes.push_back(ivl);
  endfunction

  function automatic void put_filler(input int len);
    desc_offsets.push_back(frame_bytes.size());
    frame_bytes.push_back(8'(len));
    frame_bytes.push_back(8'($urandom_range(6, 255)));
    repeat (len - 2) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void fill_to(input int target);
    int len;
    while (target - int'(frame_bytes.size()) >= 2) begin
      len = target - int'(frame_bytes.size());
      if (len > 255) len = 255;
      if (target - int'(frame_bytes.size()) - len == 1) len--;
      put_filler(len);
    end
  endfunction

  function automatic void seal_total();
    frame_bytes[2] = 8'(frame_bytes.size());
    frame_bytes[3] = 8'(frame_bytes.size() >> 8);
  endfunction

  function automatic void build_random_stream();
    int         pick;
    int         count;
    int         k;
    logic [7:0] addr;
    logic [7:0] attr;
    logic [7:0] ivl;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      count = $urandom_range(1, 24);
      repeat (count) frame_bytes.push_back(8'($urandom));
      if (count > 3 && $urandom_range(0, 1) == 1) begin
        frame_bytes[2] = 8'($urandom_range(9, 40));
        frame_bytes[3] = 8'h00;
      end
      return;
    end
    put_header(8'($urandom));
    if (pick < 14) begin
      put_iface(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      put_endpoint(8'h80 | 8'($urandom_range(0, 15)), 8'h03, 16'($urandom), 8'($urandom));
      fill_to($urandom_range(40, 120));
      seal_total();
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
      end
      return;
    end
    count = $urandom_range(0, 3);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) put_filler($urandom_range(2, 12));
      put_iface(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      repeat ($urandom_range(0, 3)) begin
        addr = 8'($urandom);
        if ($urandom_range(0, 3) != 0) addr[7] = 1'b1;
        attr = 8'($urandom);
        if ($urandom_range(0, 3) != 0) attr[1:0] = 2'b11;
        ivl = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 16));
        put_endpoint(addr, attr, 16'($urandom), ivl);
      end
    end
    seal_total();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
    end else if (pick < 20) begin
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
    end else if (pick < 28) begin
      k = desc_offsets[$urandom_range(0, desc_offsets.size() - 1)];
      frame_bytes[k] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    end else if (pick < 33) begin
      if ($urandom_range(0, 1) == 1) k = int'(frame_bytes.size()) + $urandom_range(0, 2) - 1;
      else k = $urandom_range(0, 65535);
      frame_bytes[2] = 8'(k);
      frame_bytes[3] = 8'(k >> 8);
    end
  endfunction

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'd0;
    last_byte <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= 4'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    frame_bytes.push_back(8'hA5);
    play_stream();
    frame_bytes.push_back(8'h09);
    frame_bytes.push_back(8'h02);
    frame_bytes.push_back(8'h20);
    play_stream();
    foreach (bad_totals[k]) begin
      put_header(8'h11);
      frame_bytes[2] = bad_totals[k][7:0];
      frame_bytes[3] = bad_totals[k][15:8];
      play_stream();
    end
    put_header(8'hFF);
    seal_total();
    play_stream();
    put_header(8'h01);
    put_iface(8'h00, 8'h03, 8'h01, 8'h01);
    put_endpoint(8'h81, 8'h03, 16'hFFFF, 8'hFF);
    seal_total();
    play_stream();
    put_header(8'h02);
    put_iface(8'h01, 8'hFF, 8'h00, 8'h00);
    put_endpoint(8'h02, 8'h03, 16'd64, 8'd10);
    put_endpoint(8'h83, 8'h02, 16'd512, 8'd1);
    seal_total();
    play_stream();
    put_header(8'h03);
    put_iface(8'h00, 8'h03, 8'h00, 8'h02);
    put_endpoint(8'h81, 8'h03, 16'd8, 8'd4);
    put_iface(8'h01, 8'h03, 8'h01, 8'h01);
    put_endpoint(8'h82, 8'h03, 16'd16, 8'd2);
    seal_total();
    play_stream();
    put_header(8'h04);
    put_iface(8'h00, 8'h08, 8'h06, 8'h50);
    put_iface(8'h01, 8'h03, 8'h01, 8'h02);
    put_endpoint(8'h85, 8'hFF, 16'h0840, 8'd7);
    seal_total();
    play_stream();
    foreach (short_lengths[k]) begin
      put_header(8'h05);
      put_iface(8'h02, 8'h03, 8'h00, 8'h00);
      frame_bytes.push_back(short_lengths[k]);
      frame_bytes.push_back(8'h05);
      put_endpoint(8'h81, 8'h03, 16'd8, 8'd10);
      seal_total();
      play_stream();
    end
    put_header(8'h06);
    put_iface(8'h00, 8'h03, 8'h01, 8'h01);
    put_endpoint(8'h81, 8'h03, 16'd8, 8'd10);
    seal_total();
    repeat (5) void'(frame_bytes.pop_back());
    play_stream();
    put_header(8'h07);
    put_iface(8'h00, 8'h03, 8'h01, 8'h01);
    put_endpoint(8'h81, 8'h03, 16'd8, 8'd10);
    seal_total();
    repeat (6) frame_bytes.push_back(8'($urandom));
    play_stream();
    put_header(8'h08);
    put_iface(8'h00, 8'h03, 8'h01, 8'h01);
    frame_bytes.push_back(8'd200);
    frame_bytes.push_back(8'h05);
    frame_bytes.push_back(8'h81);
    frame_bytes.push_back(8'h03);
    seal_total();
    play_stream();
    put_header(8'h09);
    put_iface(8'h00, 8'h03, 8'h01, 8'h01);
    put_endpoint(8'h81, 8'h03, 16'd8, 8'd10);
    frame_bytes[2] = 8'(MAX_TOTAL);
    frame_bytes[3] = 8'(MAX_TOTAL >> 8);
    play_stream();

    foreach (speed_codes[s]) begin
      settle();
      write_speed(speed_codes[s]);
      repeat (2) begin
        put_header(8'($urandom));
        put_iface(8'($urandom), 8'h03, 8'h00, 8'h00);
        put_endpoint(8'h81, 8'h03, 16'd8, interval_set[$urandom_range(0, 5)]);
        seal_total();
        play_stream();
      end
    end

    while (bytes_sent < ITEM_BUDGET) begin
      build_random_stream();
      play_stream();
      if ($urandom_range(0, 9) == 0) begin
        settle();
        write_speed($urandom_range(0, 1) ? speed_codes[$urandom_range(0, 3)] : 4'($urandom));
      end
    end
    settle();

    if (fail_count == 0 && results_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
